// ===== hw/rtl/bmp24_pkg.sv =====
// ----------------------------------------------------------------------------
// bmp24_pkg
// Types and constants shared by the 24-bit BMP pixel stream decoder.
// ----------------------------------------------------------------------------
package bmp24_pkg;

  // Default board size and queue depth
  localparam int unsigned BoardWidthDef  = 16;
  localparam int unsigned BoardHeightDef = 16;
  localparam int unsigned QueueDepthDef  = 4;

  // Header constants
  localparam logic [15:0] BmpSignature = 16'h4D42;
  localparam logic [15:0] BmpDepth     = 16'd24;
  localparam logic [15:0] BmpPlanes    = 16'd1;
  localparam logic [31:0] HeaderBytes  = 32'd34;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_SKIP   = 3'd1,
    PH_DATA   = 3'd2,
    PH_TRAIL  = 3'd3,
    PH_REJECT = 3'd4,
    PH_DONE   = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_REJECT = 2'd1,
    KIND_FINISH = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_SIGNATURE  = 3'd1,
    ERR_PLANES     = 3'd2,
    ERR_DEPTH      = 3'd3,
    ERR_COMPRESSED = 3'd4,
    ERR_OFFSET     = 3'd5
  } err_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
    logic       file_end;
  } in_item_t;

  typedef struct packed {
    kind_e      kind;
    err_e       error_code;
    logic [3:0] pixel_x;
    logic [3:0] pixel_y;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       run_last;
  } out_item_t;

  // All results caused by one byte: one or two of them
  typedef struct packed {
    logic      two;
    out_item_t res0;
    out_item_t res1;
  } rec_t;

endpackage

// ===== hw/rtl/bmp24_front.sv =====
// ----------------------------------------------------------------------------
// bmp24_front
// Header parser and pixel data walker; turns each byte into a result record.
// ----------------------------------------------------------------------------
module bmp24_front import bmp24_pkg::*; #(
  parameter int unsigned BOARD_WIDTH  = BoardWidthDef,
  parameter int unsigned BOARD_HEIGHT = BoardHeightDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  in_item_t in_data_i,
  output logic     rec_valid_o,
  output rec_t     rec_o
);

  localparam logic [16:0] BoardW = 17'(BOARD_WIDTH);
  localparam logic [16:0] BoardH = 17'(BOARD_HEIGHT);

  // byte positions where a header field completes
  localparam logic [31:0] PosSig    = 32'd1;
  localparam logic [31:0] PosOffset = 32'd13;
  localparam logic [31:0] PosWidth  = 32'd21;
  localparam logic [31:0] PosHeight = 32'd25;
  localparam logic [31:0] PosPlanes = 32'd27;
  localparam logic [31:0] PosDepth  = 32'd29;
  localparam logic [31:0] PosComp   = 32'd33;

  localparam logic [1:0] ChBlue  = 2'd0;
  localparam logic [1:0] ChGreen = 2'd1;
  localparam logic [1:0] ChRed   = 2'd2;

  typedef struct packed {
    phase_e      phase;
    logic [31:0] pos;
    logic [31:0] offset;
    logic [15:0] width;
    logic [15:0] height;
    logic        top_down;
    logic [31:0] shift;
    logic [15:0] col;
    logic [15:0] row;
    logic [1:0]  pad;
    logic [1:0]  chan;
    logic [7:0]  blue;
    logic [7:0]  green;
  } state_t;

  state_t s_q, s_d;

  logic       emit_rej, emit_pix, emit_fin;
  err_e       err;
  logic [3:0] pix_x, pix_y;

  // next state
  always_comb begin
    state_t      base;
    logic [31:0] sh;
    logic [31:0] mag;
    logic [15:0] y;
    logic        do_data;
    logic        row_end;

    base     = (in_valid_i && in_data_i.file_start) ? '0 : s_q;
    s_d      = s_q;
    emit_rej = 1'b0;
    emit_pix = 1'b0;
    emit_fin = 1'b0;
    err      = ERR_NONE;
    pix_x    = '0;
    pix_y    = '0;
    sh       = {in_data_i.data_byte, base.shift[31:8]};
    mag      = sh[31] ? (~sh + 32'd1) : sh;
    y        = '0;
    do_data  = 1'b0;
    row_end  = 1'b0;

    if (in_valid_i) begin
      s_d = base;
      case (base.phase)
        PH_HEADER: begin
          s_d.shift = sh;
          if (base.pos == PosSig) begin
            if (sh[31:16] != BmpSignature) err = ERR_SIGNATURE;
          end else if (base.pos == PosOffset) begin
            s_d.offset = sh;
            if (sh < HeaderBytes) err = ERR_OFFSET;
          end else if (base.pos == PosWidth) begin
            if (sh[31:16] != 16'd0) err = ERR_OFFSET;
            else s_d.width = sh[15:0];
          end else if (base.pos == PosHeight) begin
            if (sh[31]) s_d.top_down = 1'b1;
            if (mag[31:16] != 16'd0) err = ERR_OFFSET;
            else s_d.height = mag[15:0];
          end else if (base.pos == PosPlanes) begin
            if (sh[31:16] != BmpPlanes) err = ERR_PLANES;
          end else if (base.pos == PosDepth) begin
            if (sh[31:16] != BmpDepth) err = ERR_DEPTH;
          end else if (base.pos == PosComp) begin
            if (sh != 32'd0) err = ERR_COMPRESSED;
            else if (base.width == 16'd0 || base.height == 16'd0) s_d.phase = PH_TRAIL;
            else s_d.phase = PH_SKIP;
          end
          if (err != ERR_NONE) begin
            s_d.phase = PH_REJECT;
            emit_rej  = 1'b1;
          end
        end
        PH_SKIP: begin
          if (base.pos >= base.offset) begin
            s_d.phase = PH_DATA;
            do_data   = 1'b1;
          end
        end
        PH_DATA: do_data = 1'b1;
        default: ;
      endcase

      if (do_data) begin
        if (s_d.pad != 2'd0) begin
          s_d.pad = s_d.pad - 2'd1;
          if (s_d.pad == 2'd0) row_end = 1'b1;
        end else begin
          case (s_d.chan)
            ChBlue: begin
              s_d.blue = in_data_i.data_byte;
              s_d.chan = ChGreen;
            end
            ChGreen: begin
              s_d.green = in_data_i.data_byte;
              s_d.chan  = ChRed;
            end
            default: begin
              s_d.chan = ChBlue;
              y = s_d.top_down ? s_d.row : (s_d.height - 16'd1 - s_d.row);
              if ({1'b0, s_d.col} < BoardW && {1'b0, y} < BoardH) begin
                emit_pix = 1'b1;
                pix_x    = s_d.col[3:0];
                pix_y    = y[3:0];
              end
              s_d.col = s_d.col + 16'd1;
              if (s_d.col >= s_d.width) begin
                s_d.pad = s_d.width[1:0];
                if (s_d.width[1:0] == 2'd0) row_end = 1'b1;
              end
            end
          endcase
        end
        if (row_end) begin
          s_d.col = '0;
          s_d.row = s_d.row + 16'd1;
          if (s_d.row >= s_d.height) s_d.phase = PH_TRAIL;
        end
      end

      if (base.pos != '1) s_d.pos = base.pos + 32'd1;

      if (in_data_i.file_end && s_d.phase != PH_DONE) begin
        s_d.phase = PH_DONE;
        emit_fin  = 1'b1;
      end
    end
  end

  // result record
  always_comb begin
    out_item_t fin;
    fin          = '0;
    fin.kind     = KIND_FINISH;
    fin.run_last = 1'b1;

    rec_o      = '0;
    rec_o.two  = (emit_rej || emit_pix) && emit_fin;
    rec_o.res1 = fin;
    if (emit_rej) begin
      rec_o.res0.kind       = KIND_REJECT;
      rec_o.res0.error_code = err;
    end else if (emit_pix) begin
      rec_o.res0.kind    = KIND_PIXEL;
      rec_o.res0.pixel_x = pix_x;
      rec_o.res0.pixel_y = pix_y;
      rec_o.res0.red     = in_data_i.data_byte;
      rec_o.res0.green   = s_d.green;
      rec_o.res0.blue    = s_d.blue;
    end else begin
      rec_o.res0 = fin;
    end
    rec_o.res0.run_last = !rec_o.two;
    rec_valid_o = emit_rej || emit_pix || emit_fin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q <= '0;
    end else begin
      s_q <= s_d;
    end
  end

`ifndef SYNTHESIS
  // once finished, only a new file leaves the finished phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_q.phase == PH_DONE && !(in_valid_i && in_data_i.file_start))
      |=> s_q.phase == PH_DONE)
    else $error("left finished phase without file start");

  // a finish is never followed by another result of the same byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rec_valid_o && rec_o.two) |-> rec_o.res0.kind != KIND_FINISH)
    else $error("finish placed before another result");

  // records come only from accepted bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_valid_o |-> in_valid_i)
    else $error("result record without an accepted byte");
`endif

endmodule

// ===== hw/rtl/bmp24_queue.sv =====
// ----------------------------------------------------------------------------
// bmp24_queue
// Short queue of result records between the parser and the output side.
// ----------------------------------------------------------------------------
module bmp24_queue import bmp24_pkg::*; #(
  parameter int unsigned DEPTH = QueueDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_en_i,
  input  rec_t wr_data_i,
  output logic full_o,
  input  logic rd_en_i,
  output rec_t rd_data_o,
  output logic rd_valid_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  rec_t            slot_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == CntW'(DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en_i && !rd_en_i) cnt_d = cnt_q + 1'b1;
    else if (!wr_en_i && rd_en_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) slot_q[wr_ptr_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) wr_en_i |-> !full_o)
    else $error("record written into a full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni) rd_en_i |-> rd_valid_o)
    else $error("record read from an empty queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en_i && !rd_en_i) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count lost a write");
`endif

endmodule

// ===== hw/rtl/bmp24_back.sv =====
// ----------------------------------------------------------------------------
// bmp24_back
// Output side: unpacks each record into one or two results for the receiver.
// ----------------------------------------------------------------------------
module bmp24_back import bmp24_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  rec_t      rd_data_i,
  input  logic      rd_valid_i,
  output logic      rd_en_o,
  input  logic      pop_i,
  output logic      empty_o,
  output out_item_t out_data_o
);

  rec_t cur_q;
  logic valid_q, valid_d;
  logic idx_q, idx_d;
  logic last;

  assign last       = !cur_q.two || idx_q;
  assign empty_o    = !valid_q;
  assign out_data_o = idx_q ? cur_q.res1 : cur_q.res0;
  assign rd_en_o    = rd_valid_i && (!valid_q || (pop_i && last));

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (rd_en_o) begin
      valid_d = 1'b1;
      idx_d   = 1'b0;
    end else if (valid_q && pop_i) begin
      if (last) valid_d = 1'b0;
      else idx_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_o) cur_q <= rd_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

endmodule

// ===== hw/rtl/bmp24_pixel_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// bmp24_pixel_stream_decoder
// Parses a 24-bit uncompressed BMP byte stream into board pixels.
// ----------------------------------------------------------------------------
// Input channel: one file byte per request, with start-of-file and
// end-of-file marks. A request is taken when push is high and full is low.
// Result channel: pixel, rejection and finish results, oldest first; the
// head result sits on out_data_o while empty is low and leaves on pop.
// run_last marks the final result caused by a single byte.
//
// Throughput: one byte per cycle while full is low; each byte only
// updates counters and compares in the parser. Bytes without results
// never touch the queue. With the output side idle, a result is written
// into the queue at the edge that takes its byte and is then loaded
// into the output register, which drives out_data_o.
// A byte can cause two results (pixel or rejection, then finish); these
// travel as one record and leave over two pops.
// Stall: when the receiver holds off, records collect in the
// QUEUE_DEPTH-entry queue; full rises once it is full, so the parser
// stops taking bytes and nothing is dropped.
// Reset: parser in the header phase at byte zero, queue and output empty.
// ----------------------------------------------------------------------------
module bmp24_pixel_stream_decoder import bmp24_pkg::*; #(
  parameter int unsigned BOARD_WIDTH  = BoardWidthDef,
  parameter int unsigned BOARD_HEIGHT = BoardHeightDef,
  parameter int unsigned QUEUE_DEPTH  = QueueDepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_data_i,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_data_o
);

  logic accept;
  logic rec_valid;
  rec_t rec;
  logic q_full;
  logic q_rd_en;
  logic q_rd_valid;
  rec_t q_rd_data;

  // the parser stops only on a full queue, never on the receiver directly
  assign full   = q_full;
  assign accept = push && !q_full;

  bmp24_front #(
    .BOARD_WIDTH (BOARD_WIDTH),
    .BOARD_HEIGHT(BOARD_HEIGHT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (accept),
    .in_data_i  (in_data_i),
    .rec_valid_o(rec_valid),
    .rec_o      (rec)
  );

  bmp24_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (rec_valid),
    .wr_data_i (rec),
    .full_o    (q_full),
    .rd_en_i   (q_rd_en),
    .rd_data_o (q_rd_data),
    .rd_valid_o(q_rd_valid)
  );

  // output register: unpacks records one result per pop
  bmp24_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_data_i (q_rd_data),
    .rd_valid_i(q_rd_valid),
    .rd_en_o   (q_rd_en),
    .pop_i     (pop),
    .empty_o   (empty),
    .out_data_o(out_data_o)
  );

endmodule
